FILE: rtl/dhkv_pkg.sv
package dhkv_pkg;

  localparam int SZ_W  = 11;
  localparam int KEY_W = 28;
  localparam int TY_W  = 3;
  localparam int KT_W  = 30;
  localparam int VAL_W = 64;
  localparam int ST_W  = 3;
  localparam int SLOT_W = 10;
  localparam int DIV_W = 32;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_UPDATE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_PRESENT   = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_MISMATCH  = 3'd4;
  localparam logic [ST_W-1:0] ST_BAD_TYPE  = 3'd5;

  localparam logic [TY_W-1:0] TY_INT32   = 3'd1;
  localparam logic [TY_W-1:0] TY_SECTION = 3'd2;
  localparam logic [TY_W-1:0] TY_INT64   = 3'd3;

  // Write strobes toward the slot store
  typedef struct packed {
    logic kt_we;
    logic val_we;
    logic vld_we;
    logic vld_bit;
  } store_wr_t;

endpackage

FILE: rtl/dhkv_mod_unit.sv
module dhkv_mod_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dhkv_pkg::DIV_W-1:0] dividend,
  input  logic [dhkv_pkg::SZ_W-1:0]  divisor,
  output logic                       done,
  output logic [dhkv_pkg::SZ_W-1:0]  rem
);
  import dhkv_pkg::*;

  localparam int BITS_PER_CYC = 4;
  localparam int STEPS = DIV_W / BITS_PER_CYC;
  localparam int CNT_W = $clog2(STEPS);

  logic [DIV_W-1:0]         a_r;
  logic [SZ_W-1:0]          r_r, r_nxt;
  logic [CNT_W-1:0]         cnt_r;
  logic                     busy_r, done_r;

  // Four restoring steps per cycle, most significant bits first
  always_comb begin
    logic [SZ_W:0]   t;
    logic [SZ_W-1:0] r;
    r = r_r;
    for (int i = 0; i < BITS_PER_CYC; i++) begin
      t = {r, a_r[DIV_W-1-i]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      r = t[SZ_W-1:0];
    end
    r_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= dividend;
        r_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        a_r   <= a_r << BITS_PER_CYC;
        r_r   <= r_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = r_r;

endmodule

FILE: rtl/dhkv_store.sv
module dhkv_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  dhkv_pkg::store_wr_t        wr,
  input  logic [AW-1:0]              wr_addr,
  input  logic [dhkv_pkg::KT_W-1:0]  wr_kt,
  input  logic [dhkv_pkg::VAL_W-1:0] wr_val,
  input  logic [AW-1:0]              rd_addr,
  output logic                       rd_vld,
  output logic [dhkv_pkg::KT_W-1:0]  rd_kt,
  output logic [dhkv_pkg::VAL_W-1:0] rd_val
);
  import dhkv_pkg::*;

  logic             vld_mem [DEPTH];
  logic [KT_W-1:0]  kt_mem  [DEPTH];
  logic [VAL_W-1:0] val_mem [DEPTH];

  // Write ports
  always_ff @(posedge clk) begin
    if (wr.vld_we) begin
      vld_mem[wr_addr] <= wr.vld_bit;
    end
    if (wr.kt_we) begin
      kt_mem[wr_addr] <= wr_kt;
    end
    if (wr.val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_vld <= vld_mem[rd_addr];
    rd_kt  <= kt_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

endmodule

FILE: rtl/double_hash_key_value_table.sv
// Double-hashed key/value table. Raise start while busy is low to hand in a transaction; one
// result appears on the out_ ports for exactly one cycle with out_strobe, and the receiver
// cannot stall it. A lookup, insert or update holds busy while it runs, and its result
// strobes in the same cycle that busy drops: two remainders by the table size run on one
// shared 4-bit-per-cycle modulo unit, then each probe is one read and one check of the slot
// store. An insert or update with a bad entry type is answered in the cycle after it is
// taken, without raising busy. A clear sweeps the valid bits one slot per cycle with busy
// high and strobes its result in the same cycle that busy drops. After reset the same sweep
// runs with busy high and gives no result; configuration writes are taken at any time.
// The user must see that table_size is written through cfg_we and cfg_wdata only while the
// block is idle; the block itself does not enforce this.
module double_hash_key_value_table #(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_operation,
  input  logic [dhkv_pkg::KEY_W-1:0] in_key,
  input  logic [dhkv_pkg::TY_W-1:0]  in_entry_type,
  input  logic [dhkv_pkg::VAL_W-1:0] in_value,
  output logic                       out_strobe,
  output logic [dhkv_pkg::ST_W-1:0]  out_status,
  output logic [1:0]                 out_found_type,
  output logic [dhkv_pkg::VAL_W-1:0] out_found_value,
  output logic [dhkv_pkg::SLOT_W-1:0] out_slot,
  input  logic                       cfg_we,
  input  logic [dhkv_pkg::SZ_W-1:0]  cfg_wdata
);
  import dhkv_pkg::*;

  localparam int AW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HOME,
    S_STEP,
    S_RD,
    S_CHK,
    S_CLR
  } state_t;

  state_t            state_r, state_nxt;
  logic [SZ_W-1:0]   size_r;
  op_t               op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [TY_W-1:0]   ty_r, ty_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [SZ_W-1:0]   stp_r, stp_nxt;
  logic [SZ_W-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]     clr_idx_r, clr_idx_nxt;
  logic              clr_rep_r, clr_rep_nxt;
  logic              ostb_r, ostb_nxt;
  logic [ST_W-1:0]   ost_r, ost_nxt;
  logic [1:0]        oty_r, oty_nxt;
  logic [VAL_W-1:0]  oval_r, oval_nxt;
  logic [SLOT_W-1:0] oslot_r, oslot_nxt;

  logic [SZ_W-1:0]   eff_size;
  logic              mod_start, mod_done;
  logic [DIV_W-1:0]  mod_a;
  logic [SZ_W-1:0]   mod_rem;
  logic [15:0]       folded;
  logic [SZ_W:0]     pos_sum;
  logic [SZ_W-1:0]   pos_adv;
  logic              holds, ty_ok;
  logic [VAL_W-1:0]  wr_val;
  store_wr_t         wr;
  logic [AW-1:0]     wr_addr;
  logic              rd_vld;
  logic [KT_W-1:0]   rd_kt;
  logic [VAL_W-1:0]  rd_val;

  // Clamp the configured size into 1..DEPTH
  always_comb begin
    if (size_r == '0) begin
      eff_size = SZ_W'(1);
    end else if (32'(size_r) > DEPTH) begin
      eff_size = SZ_W'(DEPTH);
    end else begin
      eff_size = size_r;
    end
  end

  assign folded  = {4'd0, in_key[KEY_W-1:16]} ^ in_key[15:0];
  assign pos_sum = (SZ_W + 1)'(pos_r) + (SZ_W + 1)'(stp_r);
  assign pos_adv = (pos_sum >= (SZ_W + 1)'(eff_size)) ?
                   SZ_W'(pos_sum - (SZ_W + 1)'(eff_size)) : SZ_W'(pos_sum);
  assign holds   = rd_vld && (rd_kt[KEY_W-1:0] == key_r);
  assign wr_val  = (ty_r == TY_INT64) ? val_r : {32'd0, val_r[31:0]};

  dhkv_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_a),
    .divisor  (eff_size),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  dhkv_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .wr_kt   ({ty_r[1:0], key_r}),
    .wr_val  (wr_val),
    .rd_addr (pos_r),
    .rd_vld  (rd_vld),
    .rd_kt   (rd_kt),
    .rd_val  (rd_val)
  );

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    ty_nxt      = ty_r;
    val_nxt     = val_r;
    pos_nxt     = pos_r;
    stp_nxt     = stp_r;
    cnt_nxt     = cnt_r;
    clr_idx_nxt = clr_idx_r;
    clr_rep_nxt = clr_rep_r;
    ostb_nxt    = 1'b0;
    ost_nxt     = ost_r;
    oty_nxt     = oty_r;
    oval_nxt    = oval_r;
    oslot_nxt   = oslot_r;
    mod_start   = 1'b0;
    mod_a       = {folded, folded};
    wr          = '0;
    wr_addr     = pos_r;
    ty_ok       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = op_t'(in_operation);
          key_nxt   = in_key;
          ty_nxt    = in_entry_type;
          val_nxt   = in_value;
          ost_nxt   = ST_OK;
          oty_nxt   = '0;
          oval_nxt  = '0;
          oslot_nxt = '0;
          case (op_t'(in_operation))
            OP_INSERT: ty_ok = (in_entry_type == TY_INT32) ||
                               (in_entry_type == TY_SECTION) ||
                               (in_entry_type == TY_INT64);
            OP_UPDATE: ty_ok = (in_entry_type == TY_INT32) ||
                               (in_entry_type == TY_INT64);
            default:   ty_ok = 1'b1;
          endcase
          if (op_t'(in_operation) == OP_CLEAR) begin
            clr_idx_nxt = '0;
            clr_rep_nxt = 1'b1;
            state_nxt   = S_CLR;
          end else if (!ty_ok) begin
            ost_nxt  = ST_BAD_TYPE;
            ostb_nxt = 1'b1;
          end else begin
            mod_start = 1'b1;
            state_nxt = S_HOME;
          end
        end
      end

      // Wait for the home slot remainder, then start the step remainder
      S_HOME: begin
        mod_a = {4'd0, key_r};
        if (mod_done) begin
          pos_nxt   = AW'(mod_rem);
          mod_start = 1'b1;
          state_nxt = S_STEP;
        end
      end

      S_STEP: begin
        if (mod_done) begin
          stp_nxt   = (mod_rem == '0) ? SZ_W'(1) : mod_rem;
          cnt_nxt   = '0;
          state_nxt = S_RD;
        end
      end

      S_RD: begin
        state_nxt = S_CHK;
      end

      // Decide on the slot just read
      S_CHK: begin
        if (op_r == OP_INSERT) begin
          if (holds) begin
            ost_nxt   = ST_PRESENT;
            oslot_nxt = SLOT_W'(pos_r);
            ostb_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else if (cnt_r >= eff_size) begin
            ost_nxt   = ST_FULL;
            ostb_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else if (!rd_vld) begin
            wr.kt_we   = 1'b1;
            wr.val_we  = 1'b1;
            wr.vld_we  = 1'b1;
            wr.vld_bit = 1'b1;
            oslot_nxt  = SLOT_W'(pos_r);
            ostb_nxt   = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            pos_nxt   = AW'(pos_adv);
            state_nxt = S_RD;
          end
        end else begin
          if (holds) begin
            ostb_nxt  = 1'b1;
            state_nxt = S_IDLE;
            if (op_r == OP_LOOKUP) begin
              oty_nxt   = rd_kt[KT_W-1:KEY_W];
              oval_nxt  = rd_val;
              oslot_nxt = SLOT_W'(pos_r);
            end else if (rd_kt[KT_W-1:KEY_W] != ty_r[1:0]) begin
              ost_nxt = ST_MISMATCH;
            end else begin
              wr.val_we = 1'b1;
              oslot_nxt = SLOT_W'(pos_r);
            end
          end else if (cnt_r >= eff_size) begin
            ost_nxt   = ST_NOT_FOUND;
            ostb_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            pos_nxt   = AW'(pos_adv);
            state_nxt = S_RD;
          end
        end
      end

      // Sweep valid bits, one slot per cycle
      S_CLR: begin
        wr.vld_we  = 1'b1;
        wr.vld_bit = 1'b0;
        wr_addr    = clr_idx_r;
        if (clr_idx_r == AW'(DEPTH - 1)) begin
          ostb_nxt  = clr_rep_r;
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_idx_r <= '0;
      clr_rep_r <= 1'b0;
      ostb_r    <= 1'b0;
      size_r    <= SZ_W'(1021);
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      clr_rep_r <= clr_rep_nxt;
      ostb_r    <= ostb_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    ty_r    <= ty_nxt;
    val_r   <= val_nxt;
    pos_r   <= pos_nxt;
    stp_r   <= stp_nxt;
    cnt_r   <= cnt_nxt;
    ost_r   <= ost_nxt;
    oty_r   <= oty_nxt;
    oval_r  <= oval_nxt;
    oslot_r <= oslot_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = ostb_r;
  assign out_status      = ost_r;
  assign out_found_type  = oty_r;
  assign out_found_value = oval_r;
  assign out_slot        = oslot_r;

endmodule
